// File: sv/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/lqs_pkg.sv
`default_nettype none
package lqs_pkg;

  localparam int DEPTH_DEFAULT = 8;
  localparam int MAX_OUT = 8;
  localparam int CNT_W = $clog2(MAX_OUT);

  localparam int OP_W = 2;
  localparam int STATUS_W = 2;
  localparam int DATA_W = 32;
  localparam int SLOT_W = 3;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 40;
  localparam int PAD_W = OUT_DATA_W - DATA_W - SLOT_W;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT,
    OP_DELETE,
    OP_TRAVERSE,
    OP_SEARCH
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK,
    STAT_OVERFLOW,
    STAT_EMPTY,
    STAT_NOTFOUND
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD,
    ST_CHK
  } state_t;

endpackage
`default_nettype wire

// File: sv/lqs_ram.sv
`default_nettype none
module lqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/linear_queue_with_search.sv
`default_nettype none
// Non-circular queue of signed 32-bit words held in a single-port-read RAM of DEPTH
// entries, with a sequencer that serves one transaction at a time. Insert and any
// operation on an empty queue go through the execute state, delete reads the head entry
// and then checks it, and traverse and search visit n entries (at most 8 for traverse,
// up to DEPTH for search); each visited entry costs one registered RAM read and one
// compare. A finished result waits in the output register while the next transaction
// is accepted.
module linear_queue_with_search #(
  parameter int DEPTH = lqs_pkg::DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [lqs_pkg::IN_DATA_W-1:0]   s_tdata,  // value
  input  logic [lqs_pkg::OP_W-1:0]        s_tuser,  // op
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [lqs_pkg::OUT_DATA_W-1:0]  m_tdata,  // data, slot, zero fill
  output logic [lqs_pkg::STATUS_W-1:0]    m_tuser,  // status
  output logic                            m_tlast   // last
);

  import lqs_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_t state, state_next;
  op_t op, op_next;
  logic signed [DATA_W-1:0] value, value_next;
  logic [IDX_W-1:0] head, head_next;
  logic [IDX_W-1:0] tail, tail_next;
  logic empty, empty_next;
  logic [IDX_W-1:0] ptr, ptr_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  logic out_valid, out_valid_next;
  status_t out_status, out_status_next;
  logic signed [DATA_W-1:0] out_data, out_data_next;
  logic [SLOT_W-1:0] out_slot, out_slot_next;
  logic out_last, out_last_next;

  logic ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_rdata;
  logic out_free;
  logic trav_last;

  lqs_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH),
    .AW(IDX_W)
  ) u_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(value),
    .raddr(ptr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head <= '0;
      tail <= '0;
      empty <= 1'b1;
      ptr <= '0;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head <= head_next;
      tail <= tail_next;
      empty <= empty_next;
      ptr <= ptr_next;
      cnt <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op <= op_next;
    value <= value_next;
    out_status <= out_status_next;
    out_data <= out_data_next;
    out_slot <= out_slot_next;
    out_last <= out_last_next;
  end

  always_comb begin
    state_next = state;
    op_next = op;
    value_next = value;
    head_next = head;
    tail_next = tail;
    empty_next = empty;
    ptr_next = ptr;
    cnt_next = cnt;
    out_valid_next = out_valid;
    out_status_next = out_status;
    out_data_next = out_data;
    out_slot_next = out_slot;
    out_last_next = out_last;
    ram_we = 1'b0;
    ram_waddr = tail;
    s_tready = (state == ST_IDLE);
    out_free = !out_valid || m_tready;
    trav_last = (ptr == tail) || (cnt == CNT_W'(MAX_OUT - 1));

    if (out_valid && m_tready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          op_next = op_t'(s_tuser);
          value_next = s_tdata;
          ptr_next = head;
          cnt_next = '0;
          if (op_t'(s_tuser) == OP_INSERT || empty) begin
            state_next = ST_EXEC;
          end else begin
            state_next = ST_RD;
          end
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_data_next = '0;
          out_slot_next = '0;
          out_last_next = 1'b1;
          state_next = ST_IDLE;
          if (op == OP_INSERT) begin
            if (empty) begin
              ram_we = 1'b1;
              ram_waddr = '0;
              head_next = '0;
              tail_next = '0;
              empty_next = 1'b0;
              out_status_next = STAT_OK;
            end else if (tail == IDX_W'(DEPTH - 1)) begin
              out_status_next = STAT_OVERFLOW;
            end else begin
              ram_we = 1'b1;
              ram_waddr = tail + 1'b1;
              tail_next = tail + 1'b1;
              out_status_next = STAT_OK;
            end
          end else begin
            out_status_next = STAT_EMPTY;
          end
        end
      end
      ST_RD: begin
        state_next = ST_CHK;
      end
      ST_CHK: begin
        unique case (op)
          OP_DELETE: begin
            if (out_free) begin
              out_valid_next = 1'b1;
              out_status_next = STAT_OK;
              out_data_next = ram_rdata;
              out_slot_next = '0;
              out_last_next = 1'b1;
              state_next = ST_IDLE;
              if (head == tail) begin
                head_next = '0;
                tail_next = '0;
                empty_next = 1'b1;
              end else begin
                head_next = head + 1'b1;
              end
            end
          end
          OP_TRAVERSE: begin
            if (out_free) begin
              out_valid_next = 1'b1;
              out_status_next = STAT_OK;
              out_data_next = ram_rdata;
              out_slot_next = SLOT_W'(ptr);
              out_last_next = trav_last;
              if (trav_last) begin
                state_next = ST_IDLE;
              end else begin
                ptr_next = ptr + 1'b1;
                cnt_next = cnt + 1'b1;
                state_next = ST_RD;
              end
            end
          end
          OP_SEARCH: begin
            if (ram_rdata == value) begin
              if (out_free) begin
                out_valid_next = 1'b1;
                out_status_next = STAT_OK;
                out_data_next = ram_rdata;
                out_slot_next = SLOT_W'(ptr);
                out_last_next = 1'b1;
                state_next = ST_IDLE;
              end
            end else if (ptr == tail) begin
              if (out_free) begin
                out_valid_next = 1'b1;
                out_status_next = STAT_NOTFOUND;
                out_data_next = '0;
                out_slot_next = '0;
                out_last_next = 1'b1;
                state_next = ST_IDLE;
              end
            end else begin
              ptr_next = ptr + 1'b1;
              state_next = ST_RD;
            end
          end
          OP_INSERT: begin
            state_next = ST_IDLE;
          end
        endcase
      end
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata = {{PAD_W{1'b0}}, out_slot, out_data};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

endmodule
`default_nettype wire

// File: sv/lqs_checker.sv
`default_nettype none
`include "assert_macros.svh"
module lqs_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_tvalid,
  input wire logic                           s_tready,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [lqs_pkg::OUT_DATA_W-1:0] m_tdata,
  input wire logic [lqs_pkg::STATUS_W-1:0]   m_tuser,
  input wire logic                           m_tlast
);

  import lqs_pkg::*;

  logic s_fire;
  logic err_result;

  assign s_fire = s_tvalid && s_tready;
  assign err_result = m_tvalid && (m_tuser != STAT_OK);

  // A stalled result keeps its contents.
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
               m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

  // Error results carry no word and no slot.
  `ASSERT_SAME(a_err_zero, clk, rst, err_result, m_tdata == '0)

  // Every error result is the only result of its transaction.
  `ASSERT_SAME(a_err_last, clk, rst, err_result, m_tlast)

  // The block serves one transaction at a time.
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, s_fire, !s_tready)

endmodule

bind linear_queue_with_search lqs_checker u_lqs_checker (.*);
`default_nettype wire

// File: dv/linear_queue_with_search_test.sv
`default_nettype none
module linear_queue_with_search_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lqs_pkg::*;

  typedef struct {
    op_t         op;
    logic [31:0] value;
    bit          wait_drained;
  } request_t;

  typedef struct {
    status_t     status;
    logic [31:0] data;
    logic [2:0]  slot;
    bit          last;
  } outcome_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata = '0;
  logic [OP_W-1:0]        s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic [STATUS_W-1:0]    m_tuser;
  logic                   m_tlast;

  request_t    requests[$];
  outcome_t    expected_outcomes[$];
  int          sent = 0;
  int          received = 0;
  int          mismatches = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  logic [31:0] q_store [DEPTH_DEFAULT];
  int          q_head = 0;
  int          q_tail = 0;
  bit          q_empty = 1'b1;

  logic [31:0] recent_words [8];
  int          recent_ptr = 0;

  linear_queue_with_search i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  function automatic void push_outcome(status_t st, logic [31:0] d, int s, bit l);
    outcome_t o;
    o.status = st;
    o.data   = d;
    o.slot   = s[2:0];
    o.last   = l;
    expected_outcomes.push_back(o);
  endfunction

  // Updates the queue image for one accepted transaction and queues the results it causes.
  function automatic void apply_request(op_t op, logic [31:0] value);
    int  i;
    int  n;
    bit  hit;
    if (op == OP_INSERT) begin
      if (q_empty) begin
        q_head = 0;
        q_tail = 0;
        q_store[0] = value;
        q_empty = 1'b0;
        push_outcome(STAT_OK, '0, 0, 1'b1);
      end else if (q_tail >= DEPTH_DEFAULT - 1) begin
        push_outcome(STAT_OVERFLOW, '0, 0, 1'b1);
      end else begin
        q_tail++;
        q_store[q_tail] = value;
        push_outcome(STAT_OK, '0, 0, 1'b1);
      end
    end else if (q_empty) begin
      push_outcome(STAT_EMPTY, '0, 0, 1'b1);
    end else begin
      case (op)
        OP_DELETE: begin
          push_outcome(STAT_OK, q_store[q_head], 0, 1'b1);
          if (q_head == q_tail) begin
            q_head = 0;
            q_tail = 0;
            q_empty = 1'b1;
          end else begin
            q_head++;
          end
        end
        OP_TRAVERSE: begin
          n = 0;
          for (i = q_head; i <= q_tail && i < DEPTH_DEFAULT && n < MAX_OUT; i++) begin
            push_outcome(STAT_OK, q_store[i], i,
                         i == q_tail || i == DEPTH_DEFAULT - 1 || n == MAX_OUT - 1);
            n++;
          end
        end
        default: begin
          hit = 1'b0;
          for (i = q_head; i <= q_tail && i < DEPTH_DEFAULT; i++) begin
            if (!hit && q_store[i] == value) begin
              push_outcome(STAT_OK, q_store[i], i, 1'b1);
              hit = 1'b1;
            end
          end
          if (!hit) push_outcome(STAT_NOTFOUND, '0, 0, 1'b1);
        end
      endcase
    end
  endfunction

  function automatic void add_request(op_t op, logic [31:0] value, bit wait_drained = 1'b0);
    request_t r;
    r.op = op;
    r.value = value;
    r.wait_drained = wait_drained;
    requests.push_back(r);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      4, 5:    return $urandom_range(0, 5);
      default: return $urandom;
    endcase
  endfunction

  // Sender: holds a transaction until it is taken, then loads the next one or idles.
  always @(posedge clk) begin
    request_t nxt;
    bit       fire;
    bit       go;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      fire = s_tvalid && s_tready;
      if (fire) begin
        apply_request(op_t'(s_tuser), s_tdata);
        sent++;
      end
      if (!s_tvalid || fire) begin
        go = requests.size() > 0 &&
             ((sent >= 120 && sent < 200) || $urandom_range(0, 99) >= 18);
        if (go && requests[0].wait_drained && expected_outcomes.size() != 0) go = 1'b0;
        if (go) begin
          nxt = requests.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= nxt.op;
          s_tdata  <= nxt.value;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  // Receiver: checks each result transaction and applies back-pressure.
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        received++;
        if (expected_outcomes.size() == 0) begin
          $error("unexpected result: status %0d data %h slot %0d last %b",
                 m_tuser, m_tdata[DATA_W-1:0], m_tdata[DATA_W+SLOT_W-1:DATA_W], m_tlast);
          mismatches++;
        end else begin
          want = expected_outcomes.pop_front();
          check_field("status", want.status, m_tuser);
          check_field("data", want.data, m_tdata[DATA_W-1:0]);
          check_field("slot", want.slot, m_tdata[DATA_W+SLOT_W-1:DATA_W]);
          check_field("last", want.last, m_tlast);
          check_field("fill", '0, m_tdata[OUT_DATA_W-1:DATA_W+SLOT_W]);
        end
      end
      if (received == 80 && !hold_done) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= (received >= 150 && received < 350) || $urandom_range(0, 99) >= 18;
      end
    end
  end

  initial begin
    int          k;
    int          r;
    int          run_left;
    int          total;
    bit          filling;
    op_t         op;
    logic [31:0] v;

    // Operations on an empty queue.
    add_request(OP_TRAVERSE, 32'h0);
    add_request(OP_DELETE, 32'hffff_ffff);
    add_request(OP_SEARCH, 32'h0);
    // Fill every slot, with a duplicate to exercise first-match search.
    add_request(OP_INSERT, 32'h8000_0000);
    add_request(OP_INSERT, 32'h7fff_ffff);
    add_request(OP_INSERT, 32'h0000_0000);
    add_request(OP_INSERT, 32'hffff_ffff);
    add_request(OP_INSERT, 32'h0000_0001);
    add_request(OP_INSERT, 32'h0000_0005);
    add_request(OP_INSERT, 32'h0000_0005);
    add_request(OP_INSERT, 32'ha5a5_a5a5);
    add_request(OP_INSERT, 32'h1111_1111);
    add_request(OP_TRAVERSE, 32'h0);
    add_request(OP_SEARCH, 32'h0000_0005);
    add_request(OP_SEARCH, 32'h1234_5678);
    // Front slots freed, but the tail is still at the end.
    add_request(OP_DELETE, 32'h0);
    add_request(OP_DELETE, 32'h0);
    add_request(OP_INSERT, 32'h2222_2222);
    add_request(OP_SEARCH, 32'h8000_0000);
    for (k = 0; k < 6; k++) add_request(OP_DELETE, $urandom);
    add_request(OP_INSERT, 32'h7fff_ffff);
    add_request(OP_TRAVERSE, 32'h0);

    foreach (recent_words[j]) recent_words[j] = $urandom;
    filling = 1'b1;
    run_left = 0;
    for (k = 0; k < 295; k++) begin
      if (run_left == 0) begin
        filling = !filling;
        run_left = $urandom_range(4, 14);
      end
      run_left--;
      r = $urandom_range(0, 99);
      if (r < (filling ? 55 : 15)) op = OP_INSERT;
      else if (r < 70) op = OP_DELETE;
      else if (r < 82) op = OP_TRAVERSE;
      else op = OP_SEARCH;
      if (op == OP_INSERT) begin
        v = pick_word();
        recent_words[recent_ptr] = v;
        recent_ptr = (recent_ptr + 1) % 8;
      end else if (op == OP_SEARCH && $urandom_range(0, 1) == 1) begin
        v = recent_words[$urandom_range(0, 7)];
      end else if (op == OP_SEARCH) begin
        v = pick_word();
      end else begin
        v = $urandom;
      end
      add_request(op, v, k == 0 || k == 150);
    end
    total = requests.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait (sent == total);
    wait (expected_outcomes.size() == 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire

// File: linear_queue_with_search.f
+incdir+sv
sv/lqs_pkg.sv
sv/lqs_ram.sv
sv/linear_queue_with_search.sv
sv/lqs_checker.sv
dv/linear_queue_with_search_test.sv
